FILE: hw/rtl/lsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants of the 3x3 Laplacian sharpening block.
// ----------------------------------------------------------------------------
package lsh_pkg;

    // default line store depth
    localparam int MAX_WIDTH_DEF = 1024;

    // configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 12;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam int WIDTH_RESET  = 512;
    localparam int HEIGHT_RESET = 512;
    localparam int MIN_DIM      = 3;

    // input word
    typedef struct packed {
        logic [7:0] pixel_in;
        logic       flush;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [7:0] pixel_out;
        logic       last_of_frame;
    } t_out_word;

    // 3x3 window, cell r*3+c, column 2 is the newest
    typedef logic [8:0][7:0] t_window;

    // per-word control decoded from the frame position
    typedef struct packed {
        logic       keep;       // word enters the pipeline
        logic       emit_old;   // result is window cell 5 before the shift
        logic       emit_main;  // result comes from the shifted window
        logic       last;       // final word of the frame
        logic       interior;   // sharpen instead of pass-through
        logic       shift;      // window takes a new column
        logic       wr_line;    // line stores are updated
        logic [7:0] fresh;      // pixel entering the bottom row
    } t_item_ctrl;

endpackage
`default_nettype wire

FILE: hw/rtl/lsh_frame_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_frame_ctrl
// Image size registers, row/column counters and drain sequencing; decodes
// what each incoming word does.
// ----------------------------------------------------------------------------
module lsh_frame_ctrl #(
    parameter int  MAX_WIDTH = lsh_pkg::MAX_WIDTH_DEF,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lsh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lsh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_accept,
    input  wire lsh_pkg::t_in_word              i_word,
    output lsh_pkg::t_item_ctrl                 o_ctrl,
    output logic [AW-1:0]                       o_col
);
    import lsh_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    localparam logic [1:0] DRN_TAKE  = 2'd0;
    localparam logic [1:0] DRN_TAIL  = 2'd1;
    localparam logic [1:0] DRN_FINAL = 2'd2;

    logic [WW-1:0]           r_w, n_w;
    logic [HEIGHT_REG_W-1:0] r_h, n_h;
    logic [HEIGHT_REG_W-1:0] r_row;
    logic [AW-1:0]           r_col;
    logic [1:0]              r_drain;
    logic [CW-1:0]           cfg_w;
    logic                    col_last;
    logic                    row_last;

    // clamp written sizes to the usable range
    always_comb begin
        cfg_w = CW'(i_cfg_data[WIDTH_REG_W-1:0]);
        if (cfg_w < CW'(MIN_DIM)) begin
            n_w = WW'(MIN_DIM);
        end else if (cfg_w > CW'(MAX_WIDTH)) begin
            n_w = WW'(MAX_WIDTH);
        end else begin
            n_w = WW'(cfg_w);
        end
        if (i_cfg_data[HEIGHT_REG_W-1:0] < HEIGHT_REG_W'(MIN_DIM)) begin
            n_h = HEIGHT_REG_W'(MIN_DIM);
        end else begin
            n_h = i_cfg_data[HEIGHT_REG_W-1:0];
        end
    end

    assign col_last = ((WW'(r_col) + WW'(1)) == r_w);
    assign row_last = ((r_row + HEIGHT_REG_W'(1)) >= r_h);
    assign o_col    = r_col;

    // word decode
    always_comb begin
        o_ctrl = '0;
        unique case (r_drain)
            DRN_TAKE: begin
                o_ctrl.keep      = !i_word.flush;
                o_ctrl.shift     = !i_word.flush;
                o_ctrl.wr_line   = !i_word.flush;
                o_ctrl.emit_old  = !i_word.flush && (r_col == '0)
                                   && (r_row >= HEIGHT_REG_W'(2));
                o_ctrl.emit_main = !i_word.flush && (r_col != '0) && (r_row != '0);
                o_ctrl.interior  = (r_row >= HEIGHT_REG_W'(2)) && (r_col >= AW'(2));
                o_ctrl.fresh     = i_word.pixel_in;
            end
            DRN_TAIL: begin
                o_ctrl.keep      = 1'b1;
                o_ctrl.shift     = 1'b1;
                o_ctrl.emit_old  = (r_col == '0);
                o_ctrl.emit_main = (r_col != '0);
            end
            DRN_FINAL: begin
                o_ctrl.keep     = 1'b1;
                o_ctrl.emit_old = 1'b1;
                o_ctrl.last     = 1'b1;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

    // size registers and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= WW'(W_RST);
            r_h     <= HEIGHT_REG_W'(HEIGHT_RESET);
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= DRN_TAKE;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_IMAGE_WIDTH) begin
                r_w <= n_w;
            end
            if (i_cfg_idx == REG_IMAGE_HEIGHT) begin
                r_h <= n_h;
            end
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= DRN_TAKE;
        end else if (i_accept && o_ctrl.keep) begin
            if (r_drain == DRN_FINAL) begin
                r_row   <= '0;
                r_col   <= '0;
                r_drain <= DRN_TAKE;
            end else if (col_last) begin
                r_col <= '0;
                if (r_drain == DRN_TAIL) begin
                    r_drain <= DRN_FINAL;
                end else if (row_last) begin
                    r_row   <= '0;
                    r_drain <= DRN_TAIL;
                end else begin
                    r_row <= r_row + HEIGHT_REG_W'(1);
                end
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/lsh_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_line_buf
// Two line stores holding the previous two rows, registered read.
// ----------------------------------------------------------------------------
module lsh_line_buf #(
    parameter int  MAX_WIDTH = lsh_pkg::MAX_WIDTH_DEF,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_mid_we,
    input  wire logic [7:0]    i_mid_data,
    input  wire logic          i_up_we,
    input  wire logic [AW-1:0] i_up_addr,
    output logic [7:0]         o_up,
    output logic [7:0]         o_mid
);
    logic [7:0] r_upper  [MAX_WIDTH];
    logic [7:0] r_middle [MAX_WIDTH];
    logic [7:0] r_up_q;
    logic [7:0] r_mid_q;

    // middle row: read old value, write new pixel at the same column
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mid_q <= r_middle[i_rd_addr];
        end
        if (i_mid_we) begin
            r_middle[i_rd_addr] <= i_mid_data;
        end
    end

    // upper row: takes the registered middle row word when its word leaves stage 1
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_q <= r_upper[i_rd_addr];
        end
        if (i_up_we) begin
            r_upper[i_up_addr] <= r_mid_q;
        end
    end

    assign o_up  = r_up_q;
    assign o_mid = r_mid_q;

endmodule
`default_nettype wire

FILE: hw/rtl/lsh_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_window
// 3x3 pixel window, shifted left by one column per pixel.
// ----------------------------------------------------------------------------
module lsh_window (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_up,
    input  wire logic [7:0] i_mid,
    input  wire logic [7:0] i_fresh,
    output lsh_pkg::t_window o_win
);
    import lsh_pkg::*;

    t_window r_win;

    // shift in a new right column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3+0] <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= i_up;
            r_win[5] <= i_mid;
            r_win[8] <= i_fresh;
        end
    end

    assign o_win = r_win;

endmodule
`default_nettype wire

FILE: hw/rtl/lsh_sharpen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsh_sharpen
// Laplacian kernel: centre + (8*centre - neighbours)/16, saturated to 8 bits.
// ----------------------------------------------------------------------------
module lsh_sharpen (
    input  wire lsh_pkg::t_window i_win,
    output logic [7:0]            o_pix
);
    import lsh_pkg::*;

    logic [10:0]       nsum;
    logic signed [12:0] lap;
    logic signed [12:0] adj;
    logic signed [12:0] quo;
    logic signed [9:0]  val;

    always_comb begin
        // sum of the eight neighbours
        nsum = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                nsum = nsum + 11'(i_win[k]);
            end
        end
        lap = $signed({2'b00, i_win[4], 3'b000}) - $signed({2'b00, nsum});
        // divide by 16, rounding toward zero
        adj = lap + (lap[12] ? 13'sd15 : 13'sd0);
        quo = adj >>> 4;
        val = $signed({2'b00, i_win[4]}) + $signed(quo[9:0]);
        // saturate
        if (val < 10'sd0) begin
            o_pix = 8'd0;
        end else if (val > 10'sd255) begin
            o_pix = 8'd255;
        end else begin
            o_pix = val[7:0];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/laplacian_sharpen_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// Streaming 3x3 Laplacian sharpening of 8-bit grayscale frames.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock in raster order and returns at most one
// result word per clock, both while not stalled. Each word passes a
// three-register pipeline (line store read, window shift, output register);
// in frame terms a result follows its pixel by
// one line plus one pixel, and after the last pixel of a frame image_width+1
// flush words drain the tail, the last result carrying last_of_frame. Flush
// words sent while pixels are still expected are dropped. The line stores are
// simple dual-port RAMs of MAX_WIDTH bytes with no clearing after reset;
// unwritten entries never reach a result. Writing image_width or image_height
// restarts the frame and must be done while the block is idle.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3 #(
    parameter int MAX_WIDTH = lsh_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lsh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lsh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire lsh_pkg::t_in_word              i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output lsh_pkg::t_out_word                  o_out_data
);
    import lsh_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    t_item_ctrl    ctrl;
    logic [AW-1:0] col;
    logic [7:0]    up;
    logic [7:0]    mid;
    t_window       win;
    logic [7:0]    sharp;

    logic out_free, s2_go, s2_free, s1_go, s1_free, accept;

    logic          r_s1_v;
    t_item_ctrl    r_s1_ctrl;
    logic [AW-1:0] r_s1_addr;

    logic       r_s2_v;
    logic       r_s2_emit;
    logic       r_s2_old;
    logic [7:0] r_s2_old_pix;
    logic       r_s2_interior;
    logic       r_s2_last;

    logic      r_out_v;
    t_out_word r_out;

    // pipeline flow: a stage moves when the next one is empty or moving
    assign out_free   = !r_out_v || !i_out_stall;
    assign s2_go      = r_s2_v && (out_free || !r_s2_emit);
    assign s2_free    = !r_s2_v || s2_go;
    assign s1_go      = r_s1_v && s2_free;
    assign s1_free    = !r_s1_v || s1_go;
    assign accept     = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    lsh_frame_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_word     (i_in_data),
        .o_ctrl     (ctrl),
        .o_col      (col)
    );

    lsh_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lines (
        .i_clk      (i_clk),
        .i_rd_en    (accept && ctrl.keep),
        .i_rd_addr  (col),
        .i_mid_we   (accept && ctrl.wr_line),
        .i_mid_data (ctrl.fresh),
        .i_up_we    (s1_go && r_s1_ctrl.wr_line),
        .i_up_addr  (r_s1_addr),
        .o_up       (up),
        .o_mid      (mid)
    );

    lsh_window u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_go && r_s1_ctrl.shift),
        .i_up    (up),
        .i_mid   (mid),
        .i_fresh (r_s1_ctrl.fresh),
        .o_win   (win)
    );

    lsh_sharpen u_sharp (
        .i_win (win),
        .o_pix (sharp)
    );

    // stage 1: line store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= ctrl.keep;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctrl <= ctrl;
            r_s1_addr <= col;
        end
    end

    // stage 2: window shifted, old centre-right cell kept for border words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_go) begin
            r_s2_v <= 1'b1;
        end else if (s2_go) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_emit     <= r_s1_ctrl.emit_old || r_s1_ctrl.emit_main;
            r_s2_old      <= r_s1_ctrl.emit_old;
            r_s2_old_pix  <= win[5];
            r_s2_interior <= r_s1_ctrl.interior;
            r_s2_last     <= r_s1_ctrl.last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s2_go && r_s2_emit) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && r_s2_emit) begin
            if (r_s2_old) begin
                r_out.pixel_out <= r_s2_old_pix;
            end else if (r_s2_interior) begin
                r_out.pixel_out <= sharp;
            end else begin
                r_out.pixel_out <= win[4];
            end
            r_out.last_of_frame <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
